### design/sra_pkg.sv
package sra_pkg;

    localparam int ACT_W  = 2;
    localparam int IDX_W  = 5;
    localparam int SIZE_W = 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

    localparam int SCAN_FIRST = 2;
    localparam int SCAN_LAST  = 14;
    localparam logic [IDX_W-1:0] FALLBACK_REG = 5'd1;

    localparam logic [SIZE_W-1:0] SIZE_MAX    = 4'd8;
    localparam logic [SIZE_W-1:0] SIZE_WIDE   = 4'd8;
    localparam logic [SIZE_W-1:0] SIZE_NARROW = 4'd4;

    typedef struct packed {
        logic              in_use;
        logic [SIZE_W-1:0] granted_size;
        logic [IDX_W-1:0]  granted_index;
        logic              granted;
    } res_t;

    typedef struct packed {
        logic [SIZE_W-1:0] req_size;
        logic [IDX_W-1:0]  reg_index;
        logic [ACT_W-1:0]  action;
    } item_t;

    // fixed minimum width per register, bytes
    function automatic logic [SIZE_W-1:0] min_width(input logic [IDX_W-1:0] r);
        logic [SIZE_W-1:0] w;
        begin
            if (r <= 5'd4)
                w = 4'd1;
            else if (r <= 5'd6)
                w = 4'd2;
            else if (r <= 5'd14)
                w = 4'd8;
            else if (r <= 5'd16)
                w = 4'd2;
            else
                w = 4'd8;
            return w;
        end
    endfunction

endpackage

### design/sra_core.sv
module sra_core #(
    parameter int NUM_REGS = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  sra_pkg::item_t            item,
    output sra_pkg::res_t             result
);

    localparam int IW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int ScanLast = (sra_pkg::SCAN_LAST < NUM_REGS - 1) ?
                              sra_pkg::SCAN_LAST : NUM_REGS - 1;

    logic [sra_pkg::SIZE_W-1:0] table_reg [NUM_REGS];

    logic [sra_pkg::SIZE_W-1:0] size_sat;
    logic [sra_pkg::SIZE_W-1:0] req_eff;
    logic [sra_pkg::SIZE_W-1:0] mw_idx;
    logic [sra_pkg::SIZE_W-1:0] entry;
    logic                       idx_ok;
    logic [IW-1:0]              idx_sel;
    logic [NUM_REGS-1:0]        fit;
    logic                       scan_hit;
    logic [sra_pkg::IDX_W-1:0]  scan_pick;

    logic                       wr_en;
    logic [IW-1:0]              wr_idx;
    logic [sra_pkg::SIZE_W-1:0] wr_val;

    assign size_sat = (item.req_size > sra_pkg::SIZE_MAX) ? sra_pkg::SIZE_MAX : item.req_size;
    assign idx_ok   = (32'(item.reg_index) < 32'(NUM_REGS));
    assign idx_sel  = item.reg_index[IW-1:0];
    assign entry    = idx_ok ? table_reg[idx_sel] : '0;
    assign mw_idx   = sra_pkg::min_width(item.reg_index);
    assign req_eff  = (size_sat != '0) ? size_sat :
                      ((mw_idx == sra_pkg::SIZE_WIDE) ? sra_pkg::SIZE_WIDE
                                                      : sra_pkg::SIZE_NARROW);

    // per-register fit for the allocate scan
    always_comb
    begin
        for (int r = 0; r < NUM_REGS; r++)
        begin
            fit[r] = (table_reg[r] == '0) &&
                     (sra_pkg::min_width(5'(r)) <= size_sat);
        end
    end

    // lowest fitting register in the scan window
    always_comb
    begin
        scan_hit  = 1'b0;
        scan_pick = '0;
        for (int r = ScanLast; r >= sra_pkg::SCAN_FIRST; r--)
        begin
            if (fit[r])
            begin
                scan_hit  = 1'b1;
                scan_pick = 5'(r);
            end
        end
    end

    always_comb
    begin
        result = '0;
        wr_en  = 1'b0;
        wr_idx = idx_sel;
        wr_val = '0;
        unique case (item.action)
            sra_pkg::ACT_REQUEST:
            begin
                if (idx_ok && entry == '0 && mw_idx <= req_eff)
                begin
                    result.granted       = 1'b1;
                    result.granted_index = item.reg_index;
                    result.granted_size  = req_eff;
                    wr_en  = 1'b1;
                    wr_val = req_eff;
                end
            end
            sra_pkg::ACT_ALLOC:
            begin
                if (size_sat != '0)
                begin
                    if (scan_hit)
                    begin
                        result.granted       = 1'b1;
                        result.granted_index = scan_pick;
                        result.granted_size  = size_sat;
                        wr_en  = 1'b1;
                        wr_idx = scan_pick[IW-1:0];
                        wr_val = size_sat;
                    end
                    else if (fit[sra_pkg::FALLBACK_REG])
                    begin
                        result.granted       = 1'b1;
                        result.granted_index = sra_pkg::FALLBACK_REG;
                        result.granted_size  = size_sat;
                        wr_en  = 1'b1;
                        wr_idx = sra_pkg::FALLBACK_REG[IW-1:0];
                        wr_val = size_sat;
                    end
                end
            end
            sra_pkg::ACT_FREE:
            begin
                if (idx_ok)
                begin
                    result.granted       = 1'b1;
                    result.granted_index = item.reg_index;
                    wr_en = 1'b1;
                end
            end
            sra_pkg::ACT_QUERY:
            begin
                result.in_use = (entry != '0);
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                table_reg[r] <= '0;
            end
        end
        else if (en && wr_en)
        begin
            table_reg[wr_idx] <= wr_val;
        end
    end

endmodule

### design/sized_register_allocator.sv
// Channel   Dir  Word width  Fields, lowest bit first
// s_axis    in   16          action[1:0], reg_index[6:2], req_size[10:7], zero fill
// m_axis    out  16          granted[0], granted_index[5:1], granted_size[9:6],
//                            in_use[10], zero fill
//
// One word in, one word out. There are two register stages, the input register and
// the result register; a word moves into the result register when it is empty or
// being drained. One word can be accepted every cycle while m_axis does not stall.
// The allocation table is updated at the edge the word moves from the input
// register to the result register, so the next word always sees it.
// Reset (rst_n low) frees all registers and empties both stages.
// A stall on m_axis holds the result register; the input register keeps
// taking one more word, then s_axis_tready drops.
module sized_register_allocator #(
    parameter int NUM_REGS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action, reg_index, req_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // granted, granted_index, granted_size, in_use
);

    localparam int ItemW = $bits(sra_pkg::item_t);
    localparam int ResW  = $bits(sra_pkg::res_t);

    logic            in_valid_reg;
    logic            in_valid_next;
    sra_pkg::item_t  in_item_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    sra_pkg::res_t   out_res_reg;
    sra_pkg::res_t   core_res;
    logic            advance;
    logic            take_in;

    // word moves forward when the result slot is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            (m_axis_tready ? 1'b0 : out_valid_reg);

    sra_core #(
        .NUM_REGS (NUM_REGS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= s_axis_tdata[ItemW-1:0];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-ResW){1'b0}}, out_res_reg};

endmodule

### dv/sized_register_allocator_test.sv
module sized_register_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS = 17;

    // Run length: ~1350 words, split evenly over the three idle/stall phases.
    localparam int WORDS_PER_PHASE = 450;

    // Directed rows. When "typed" is set, the result in the row is the expected
    // word; otherwise the expected word comes from the table model below.
    typedef struct {
        logic [sra_pkg::ACT_W-1:0]  act;
        logic [sra_pkg::IDX_W-1:0]  idx;
        logic [sra_pkg::SIZE_W-1:0] sz;
        bit                         typed;
        logic                       g;
        logic [sra_pkg::IDX_W-1:0]  gi;
        logic [sra_pkg::SIZE_W-1:0] gs;
        logic                       iu;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;

    plan_row_t plan [PLAN_ROWS] = '{
        // empty after reset, both in and out of range
        '{sra_pkg::ACT_QUERY,   5'd0,  4'd0,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_QUERY,   5'd31, 4'd15, 1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        // 8-byte register refuses a 4-byte ask, takes a zero-size ask as 8
        '{sra_pkg::ACT_REQUEST, 5'd7,  4'd4,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd7,  4'd0,  1'b1, 1'b1, 5'd7,  4'd8, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd7,  4'd8,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_QUERY,   5'd7,  4'd0,  1'b1, 1'b0, 5'd0,  4'd0, 1'b1},
        // size above eight saturates
        '{sra_pkg::ACT_REQUEST, 5'd0,  4'd15, 1'b1, 1'b1, 5'd0,  4'd8, 1'b0},
        // zero size on a narrow register becomes 4
        '{sra_pkg::ACT_REQUEST, 5'd5,  4'd0,  1'b1, 1'b1, 5'd5,  4'd4, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd16, 4'd1,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd16, 4'd2,  1'b1, 1'b1, 5'd16, 4'd2, 1'b0},
        // index past the table
        '{sra_pkg::ACT_REQUEST, 5'd31, 4'd8,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd17, 4'd8,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_FREE,    5'd31, 4'd0,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        // releasing an entry that is already free still reports done
        '{sra_pkg::ACT_FREE,    5'd3,  4'd0,  1'b1, 1'b1, 5'd3,  4'd0, 1'b0},
        // allocate with zero size always fails
        '{sra_pkg::ACT_ALLOC,   5'd0,  4'd0,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_ALLOC,   5'd0,  4'd1,  1'b0, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_ALLOC,   5'd31, 4'd8,  1'b0, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_ALLOC,   5'd16, 4'd9,  1'b0, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_FREE,    5'd7,  4'd15, 1'b1, 1'b1, 5'd7,  4'd0, 1'b0},
        '{sra_pkg::ACT_QUERY,   5'd7,  4'd0,  1'b1, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_ALLOC,   5'd0,  4'd2,  1'b0, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_FREE,    5'd16, 4'd0,  1'b1, 1'b1, 5'd16, 4'd0, 1'b0},
        '{sra_pkg::ACT_REQUEST, 5'd15, 4'd10, 1'b0, 1'b0, 5'd0,  4'd0, 1'b0},
        '{sra_pkg::ACT_QUERY,   5'd15, 4'd0,  1'b0, 1'b0, 5'd0,  4'd0, 1'b0}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // action, reg_index, req_size
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // granted, granted_index, granted_size, in_use

    // model of the allocation table, one size per register (0 = free)
    logic [sra_pkg::SIZE_W-1:0] size_held [NUM_REGS];

    sra_pkg::res_t owed_results [$];
    int unsigned   mismatches     = 0;
    int unsigned   src_idle_pct   = 0;
    int unsigned   sink_stall_pct = 0;
    sra_pkg::res_t seen;
    sra_pkg::res_t owed;

    sized_register_allocator #(
        .NUM_REGS(NUM_REGS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("sized_register_allocator: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------

    // narrowest width each register can hold, bytes
    function automatic logic [sra_pkg::SIZE_W-1:0] floor_bytes(input int unsigned r);
        logic [sra_pkg::SIZE_W-1:0] w;
        case (r)
            0, 1, 2, 3, 4: w = 4'd1;
            5, 6, 15, 16:  w = 4'd2;
            default:       w = 4'd8;
        endcase
        return w;
    endfunction

    // try to claim register r at size sz; zero size picks the default width
    function automatic bit claim(input int unsigned r,
                                 input logic [sra_pkg::SIZE_W-1:0] sz,
                                 output logic [sra_pkg::SIZE_W-1:0] took);
        logic [sra_pkg::SIZE_W-1:0] s;
        took = '0;
        s    = sz;
        if (r >= NUM_REGS)
            return 1'b0;
        if (s == 0)
            s = (floor_bytes(r) == 4'd8) ? sra_pkg::SIZE_WIDE : sra_pkg::SIZE_NARROW;
        if (size_held[r] == 0 && floor_bytes(r) <= s)
        begin
            size_held[r] = s;
            took         = s;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one word to the table model and return the word it should produce
    function automatic sra_pkg::res_t apply_word(input sra_pkg::item_t w);
        sra_pkg::res_t              r;
        logic [sra_pkg::SIZE_W-1:0] sz;
        logic [sra_pkg::SIZE_W-1:0] took;
        int unsigned                last;
        r  = '0;
        sz = (w.req_size > sra_pkg::SIZE_MAX) ? sra_pkg::SIZE_MAX : w.req_size;
        case (w.action)
            sra_pkg::ACT_REQUEST:
            begin
                if (claim(32'(w.reg_index), sz, took))
                begin
                    r.granted       = 1'b1;
                    r.granted_index = w.reg_index;
                    r.granted_size  = took;
                end
            end
            sra_pkg::ACT_ALLOC:
            begin
                if (sz != 0)
                begin
                    last = (sra_pkg::SCAN_LAST > NUM_REGS - 1) ? NUM_REGS - 1
                                                               : sra_pkg::SCAN_LAST;
                    // first fit over the scan window, then the fallback register
                    for (int unsigned i = sra_pkg::SCAN_FIRST; i <= last && !r.granted; i++)
                    begin
                        if (claim(i, sz, took))
                        begin
                            r.granted       = 1'b1;
                            r.granted_index = i[sra_pkg::IDX_W-1:0];
                            r.granted_size  = took;
                        end
                    end
                    if (!r.granted && claim(32'(sra_pkg::FALLBACK_REG), sz, took))
                    begin
                        r.granted       = 1'b1;
                        r.granted_index = sra_pkg::FALLBACK_REG;
                        r.granted_size  = took;
                    end
                end
            end
            sra_pkg::ACT_FREE:
            begin
                if (w.reg_index < NUM_REGS)
                begin
                    size_held[w.reg_index] = '0;
                    r.granted              = 1'b1;
                    r.granted_index        = w.reg_index;
                end
            end
            default:
            begin
                if (w.reg_index < NUM_REGS && size_held[w.reg_index] != 0)
                    r.in_use = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // mostly legal traffic that keeps the table busy; some out-of-range
    // indexes and odd sizes mixed in
    function automatic sra_pkg::item_t random_word();
        sra_pkg::item_t w;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 30)
            w.action = sra_pkg::ACT_REQUEST;
        else if (pick < 60)
            w.action = sra_pkg::ACT_ALLOC;
        else if (pick < 85)
            w.action = sra_pkg::ACT_FREE;
        else
            w.action = sra_pkg::ACT_QUERY;
        if ($urandom_range(9) == 0)
            w.reg_index = 5'($urandom_range(31, NUM_REGS));
        else
            w.reg_index = 5'($urandom_range(NUM_REGS - 1));
        if ($urandom_range(7) == 0)
            w.req_size = 4'($urandom_range(15));
        else
            w.req_size = 4'(1 << $urandom_range(3));
        return w;
    endfunction

    // drive one word, wait for the handshake, then log what should come back
    task automatic send_word(input sra_pkg::item_t w, input bit typed,
                             input sra_pkg::res_t want);
        sra_pkg::res_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, w};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // model runs even for typed rows so the table stays in step
        pred = apply_word(w);
        owed_results.push_back(typed ? want : pred);
    endtask

    initial
    begin : stimulus
        sra_pkg::item_t w;
        sra_pkg::res_t  want;
        foreach (size_held[i])
            size_held[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: light source gaps, heavy sink stalls (directed rows too)
        src_idle_pct   = 10;
        sink_stall_pct = 75;
        foreach (plan[i])
        begin
            w.action             = plan[i].act;
            w.reg_index          = plan[i].idx;
            w.req_size           = plan[i].sz;
            want.granted         = plan[i].g;
            want.granted_index   = plan[i].gi;
            want.granted_size    = plan[i].gs;
            want.in_use          = plan[i].iu;
            send_word(w, plan[i].typed, want);
        end
        for (int n = 0; n < WORDS_PER_PHASE - PLAN_ROWS; n++)
            send_word(random_word(), 1'b0, '0);

        // phase 2: heavy source gaps, light sink stalls
        src_idle_pct   = 75;
        sink_stall_pct = 10;
        for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_word(), 1'b0, '0);

        // phase 3: back to back
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(random_word(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge clk);
        // let the clock run on to catch any stray output word
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("sized_register_allocator: match");
        else
            $display("sized_register_allocator: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic flag(input string what, input int unsigned got, input int unsigned want);
        mismatches++;
        $display("ERROR @%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata[$bits(sra_pkg::res_t)-1:0];
            if (owed_results.size() == 0)
                flag("result word with nothing pending", 32'(m_axis_tdata), 0);
            else
            begin
                owed = owed_results.pop_front();
                if (seen.granted !== owed.granted)
                    flag("granted", 32'(seen.granted), 32'(owed.granted));
                if (seen.granted_index !== owed.granted_index)
                    flag("granted_index", 32'(seen.granted_index),
                         32'(owed.granted_index));
                if (seen.granted_size !== owed.granted_size)
                    flag("granted_size", 32'(seen.granted_size),
                         32'(owed.granted_size));
                if (seen.in_use !== owed.in_use)
                    flag("in_use", 32'(seen.in_use), 32'(owed.in_use));
            end
        end
    end

endmodule
